[rtl/core/bspa_pkg.sv]
// ============================================================================
// bspa_pkg - shared types and constants of the slot pool allocator
// Chunk geometry, request/result records, status codes and FSM states.
// ============================================================================
package bspa_pkg;

    // Pool geometry
    localparam int CHUNKS     = 8;
    localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int ACT_W      = $clog2(CHUNKS + 1);
    localparam int SLOTS      = 64;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int BIT_W      = $clog2(IDX_W);
    localparam int LIN_W      = CHUNK_W + IDX_W;

    // Field widths
    localparam int SNUM_W     = 9;
    localparam int SIZE_W     = 17;
    localparam int ADDR_W     = 32;
    localparam int SPAN_W     = SIZE_W + IDX_W;
    localparam int PROD_W     = LIN_W + SIZE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [SLOTS-1:0]  ALL_FREE      = '1;
    localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] RST_SLOT_SIZE = SIZE_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_SIZE   = 1'b0,
        CFG_REGION_BASE = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_OUTSIDE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_FIND,
        S_ALLOC_TAKE,
        S_ALLOC_MUL,
        S_FREE_SCAN,
        S_FREE_DIV,
        S_DONE
    } t_state;

    // Classified request as queued between front and back end
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
    } t_req;

    // Result record; slot_address sits in the low bits when packed
    typedef struct packed {
        logic              chunk_added;
        t_status           status;
        logic [SNUM_W-1:0] slot_number;
        logic [ADDR_W-1:0] slot_address;
    } t_res;

    localparam int RES_W = $bits(t_res);

    // Index of the lowest set bit, zero when none is set
    function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/bspa_front.sv]
// ============================================================================
// bspa_front - request intake and classification
// Decodes the command, drops the address of allocate requests and holds
// up to two classified requests for the back end.
// ============================================================================
module bspa_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic [bspa_pkg::ADDR_W-1:0] i_free_address,
    output bspa_pkg::t_req            o_req,
    output logic                      o_req_valid,
    input  logic                      i_req_pop
);
    import bspa_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    t_req       w_req;
    logic       w_push;
    logic       w_pop;

    // classify
    always_comb begin
        w_req.op   = i_command ? OP_FREE : OP_ALLOC;
        w_req.addr = (w_req.op == OP_FREE) ? i_free_address : '0;
    end

    assign o_ready     = (r_count != 2'd2);
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_mem[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_req_pop && o_req_valid;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

endmodule

[rtl/core/bspa_engine.sv]
// ============================================================================
// bspa_engine - allocate / free execution
// Owns the free masks and the active chunk count. Allocate picks a chunk,
// takes its lowest free slot and forms the address; free walks the active
// chunks and divides the offset by the slot size one quotient bit a cycle.
// ============================================================================
module bspa_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bspa_pkg::SIZE_W-1:0]   i_slot_size,
    input  logic [bspa_pkg::ADDR_W-1:0]   i_region_base,
    input  bspa_pkg::t_req                i_req,
    input  logic                          i_req_valid,
    output logic                          o_req_pop,
    output bspa_pkg::t_res                o_res,
    output logic                          o_res_valid,
    input  logic                          i_res_ready
);
    import bspa_pkg::*;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_masks [CHUNKS];
    logic [SLOTS-1:0]    n_masks [CHUNKS];
    logic [ACT_W-1:0]    r_active, n_active;
    t_op                 r_op, n_op;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic                r_added, n_added;
    t_status             r_status, n_status;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [SPAN_W-1:0]   r_rem, n_rem;
    logic [BIT_W-1:0]    r_bit, n_bit;

    logic [SIZE_W-1:0]   w_size;
    logic [SPAN_W-1:0]   w_step;
    logic [SPAN_W-1:0]   w_lim;
    logic [ADDR_W-1:0]   w_off;
    logic                w_in_chunk;
    logic                w_last;
    logic [CHUNKS-1:0]   w_hit;
    logic                w_any;
    logic [CHUNK_W-1:0]  w_first;
    logic                w_pool_full;
    logic [SLOTS-1:0]    w_take_mask;
    logic [IDX_W-1:0]    w_take_idx;
    logic [SPAN_W-1:0]   w_dv;
    logic                w_qbit;
    logic [IDX_W-1:0]    w_quo;
    logic [LIN_W-1:0]    w_lin;

    // slot size zero behaves as the minimum size
    assign w_size      = (i_slot_size == '0) ? MIN_SIZE : i_slot_size;
    assign w_step      = {w_size, {IDX_W{1'b0}}};
    assign w_lim       = w_step - SPAN_W'(w_size);
    assign w_off       = r_addr - r_base;
    assign w_in_chunk  = (w_off <= ADDR_W'(w_lim));
    assign w_last      = ((ACT_W'(r_chunk) + ACT_W'(1)) >= r_active);
    assign w_pool_full = (r_active == ACT_W'(CHUNKS));
    assign w_lin       = {r_chunk, r_idx};

    // chunk pick: first active chunk with a free slot
    always_comb begin
        w_first = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            w_hit[c] = (ACT_W'(c) < r_active) && (r_masks[c] != '0);
        end
        for (int c = CHUNKS - 1; c >= 0; c--) begin
            if (w_hit[c]) begin
                w_first = CHUNK_W'(c);
            end
        end
        w_any = |w_hit;
    end

    // freshly activated chunk starts with every slot free
    assign w_take_mask = r_added ? ALL_FREE : r_masks[r_chunk];
    assign w_take_idx  = lowest_set(w_take_mask);

    // restoring division step
    assign w_dv  = SPAN_W'(w_size) << r_bit;
    assign w_qbit = (r_rem >= w_dv);
    always_comb begin
        w_quo = r_idx;
        if (w_qbit) begin
            w_quo[r_bit] = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req.op == OP_FREE) ? S_FREE_SCAN : S_ALLOC_FIND;
                end
            end
            S_ALLOC_FIND: begin
                n_state = (!w_any && w_pool_full) ? S_DONE : S_ALLOC_TAKE;
            end
            S_ALLOC_TAKE: n_state = S_ALLOC_MUL;
            S_ALLOC_MUL:  n_state = S_DONE;
            S_FREE_SCAN: begin
                if (w_in_chunk) begin
                    n_state = S_FREE_DIV;
                end else if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_masks  = r_masks;
        n_active = r_active;
        n_op     = r_op;
        n_addr   = r_addr;
        n_chunk  = r_chunk;
        n_added  = r_added;
        n_status = r_status;
        n_idx    = r_idx;
        n_prod   = r_prod;
        n_base   = r_base;
        n_rem    = r_rem;
        n_bit    = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.op;
                    n_addr   = i_req.addr;
                    n_chunk  = '0;
                    n_base   = i_region_base;
                    n_added  = 1'b0;
                    n_status = ST_OK;
                    n_idx    = '0;
                end
            end
            S_ALLOC_FIND: begin
                if (w_any) begin
                    n_chunk = w_first;
                end else if (w_pool_full) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    n_chunk = CHUNK_W'(r_active);
                    n_added = 1'b1;
                end
            end
            S_ALLOC_TAKE: begin
                n_idx            = w_take_idx;
                n_masks[r_chunk] = w_take_mask & ~(SLOTS'(1) << w_take_idx);
                if (r_added) begin
                    n_active = r_active + ACT_W'(1);
                end
            end
            S_ALLOC_MUL: begin
                n_prod = PROD_W'(w_lin) * PROD_W'(w_size);
            end
            S_FREE_SCAN: begin
                if (w_in_chunk) begin
                    n_rem = SPAN_W'(w_off);
                    n_bit = BIT_W'(IDX_W - 1);
                    n_idx = '0;
                end else if (w_last) begin
                    n_status = ST_OUTSIDE;
                end else begin
                    n_chunk = r_chunk + CHUNK_W'(1);
                    n_base  = r_base + ADDR_W'(w_step);
                end
            end
            S_FREE_DIV: begin
                n_idx = w_quo;
                if (w_qbit) begin
                    n_rem = r_rem - w_dv;
                end
                if (r_bit == '0) begin
                    n_masks[r_chunk] = r_masks[r_chunk] | (SLOTS'(1) << w_quo);
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_pop   = (r_state == S_IDLE) && i_req_valid;
        o_res_valid = (r_state == S_DONE);
        o_res.status       = r_status;
        o_res.chunk_added  = r_added && (r_status == ST_OK);
        o_res.slot_number  = (r_status == ST_OK) ? SNUM_W'(w_lin) : '0;
        o_res.slot_address = ((r_status == ST_OK) && (r_op == OP_ALLOC))
                             ? (i_region_base + ADDR_W'(r_prod)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= ACT_W'(1);
            for (int c = 0; c < CHUNKS; c++) begin
                r_masks[c] <= ALL_FREE;
            end
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_masks  <= n_masks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_chunk  <= n_chunk;
        r_added  <= n_added;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_prod   <= n_prod;
        r_base   <= n_base;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
    end

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != '0) && (r_active <= ACT_W'(CHUNKS)))
        else $error("active chunk count out of range");

    a_active_grows_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ALLOC_TAKE) |=> $stable(r_active))
        else $error("active chunk count changed outside slot take");

    a_picked_chunk_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC_TAKE) && !r_added |-> (r_masks[r_chunk] != '0))
        else $error("allocate picked a full chunk");

    a_exhausted_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == ST_EXHAUSTED) |-> w_pool_full)
        else $error("exhausted status with chunks left");

endmodule

[rtl/core/bitmap_slot_pool_allocator.sv]
// ============================================================================
// bitmap_slot_pool_allocator - fixed-size slot pool with per-chunk bitmaps
// Top level: configuration registers, front end, back end, result register.
// ============================================================================
// Each request on the slave stream is either an allocate (tuser = 0) or a
// free of the slot holding tdata (tuser = 1); each produces exactly one
// result on the master stream, in request order. Chunks of 64 slots lie back
// to back from region_base; chunk 0 is active after reset and another chunk
// is brought in when all active ones are full, up to 8 chunks. After leaving
// the queue, an allocate goes through chunk pick, slot take, one 9x17
// multiply and the result; a free walks the active chunks in order (up to
// 8) until one holds the address, then runs a restoring division of the
// offset, one quotient bit per cycle. One request is worked on at a
// time; a two-entry queue in front and the result register behind let the
// stream sides stall independently. Configuration is written through
// i_cfg_we/i_cfg_addr/i_cfg_wdata while no request is in flight. Status:
// 0 ok, 1 pool exhausted, 2 address outside pool. No clearing pass is needed
// after reset: the masks sit in flip-flops and reset to all free.
module bitmap_slot_pool_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bspa_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bspa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bspa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] free_address
    input  logic                              s_axis_tuser,  // [0] command
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] slot_address, [40:32] slot_number, [42:41] status,
    // [43] chunk_added, [47:44] zero
    output logic [bspa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bspa_pkg::*;

    logic [SIZE_W-1:0] r_slot_size;
    logic [ADDR_W-1:0] r_region_base;
    logic              r_out_valid, n_out_valid;
    t_res              r_out;

    t_req              w_req;
    logic              w_req_valid;
    logic              w_req_pop;
    t_res              w_res;
    logic              w_res_valid;
    logic              w_res_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_size   <= RST_SLOT_SIZE;
            r_region_base <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_SLOT_SIZE:   r_slot_size   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_REGION_BASE: r_region_base <= i_cfg_wdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bspa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_command      (s_axis_tuser),
        .i_free_address (s_axis_tdata[ADDR_W-1:0]),
        .o_req          (w_req),
        .o_req_valid    (w_req_valid),
        .i_req_pop      (w_req_pop)
    );

    bspa_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slot_size   (r_slot_size),
        .i_region_base (r_region_base),
        .i_req         (w_req),
        .i_req_valid   (w_req_valid),
        .o_req_pop     (w_req_pop),
        .o_res         (w_res),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready)
    );

    // result register: engine hands over when it is empty or draining
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_out};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the bitmap slot pool allocator
// Drives allocate and free requests with random gaps and result stalls, and
// compares every result against a bit-accurate model of the slot pool.
// ============================================================================

import bspa_pkg::*;

// Tracks the free bitmaps, active chunk count and registers, and queues the
// result that each accepted request must produce.
class slot_pool_scoreboard;
    logic [SLOTS-1:0]  free_map [CHUNKS];
    int                live_chunks;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] base_reg;
    t_res              expected_q [$];
    int unsigned       n_errors;
    int unsigned       n_checked;
    int unsigned       n_alloc;
    int unsigned       n_free;
    int unsigned       n_added;
    int unsigned       n_exhausted;
    int unsigned       n_outside;

    function new();
        foreach (free_map[k]) begin
            free_map[k] = ALL_FREE;
        end
        live_chunks = 1;
        size_reg    = RST_SLOT_SIZE;
        base_reg    = '0;
        n_errors    = 0;
        n_checked   = 0;
        n_alloc     = 0;
        n_free      = 0;
        n_added     = 0;
        n_exhausted = 0;
        n_outside   = 0;
    endfunction

    function void configure(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        case (r)
            CFG_SLOT_SIZE:   size_reg = v[SIZE_W-1:0];
            CFG_REGION_BASE: base_reg = v[ADDR_W-1:0];
            default: ;
        endcase
    endfunction

    // zero size behaves as the 4-byte minimum
    function logic [31:0] eff_size();
        return (size_reg == '0) ? 32'd4 : {15'b0, size_reg};
    endfunction

    function logic [31:0] chunk_start(int c);
        logic [63:0] span;
        span = 64'(c) * 64'(SLOTS) * 64'(eff_size());
        return base_reg + span[31:0];
    endfunction

    function bit pool_full();
        bit any_free;
        any_free = 0;
        for (int k = 0; k < live_chunks; k++) begin
            if (free_map[k] != '0) begin
                any_free = 1;
            end
        end
        return (live_chunks == CHUNKS) && !any_free;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(t_op op, logic [31:0] addr);
        t_res        r;
        int          pick;
        int          idx;
        logic [31:0] eff;
        logic [31:0] off;
        r    = '0;
        pick = -1;
        idx  = -1;
        eff  = eff_size();
        if (op == OP_ALLOC) begin
            n_alloc++;
            for (int k = 0; k < live_chunks; k++) begin
                if (pick < 0 && free_map[k] != '0) begin
                    pick = k;
                end
            end
            // every active chunk full: bring in the next one, if any is left
            if (pick < 0) begin
                if (live_chunks >= CHUNKS) begin
                    r.status = ST_EXHAUSTED;
                    n_exhausted++;
                end else begin
                    pick = live_chunks;
                    free_map[pick] = ALL_FREE;
                    live_chunks++;
                    r.chunk_added = 1'b1;
                    n_added++;
                end
            end
            if (pick >= 0) begin
                for (int b = 0; b < SLOTS; b++) begin
                    if (idx < 0 && free_map[pick][b]) begin
                        idx = b;
                    end
                end
                free_map[pick][idx] = 1'b0;
                r.slot_address = chunk_start(pick) + 32'(idx) * eff;
                r.slot_number  = 9'(pick * SLOTS + idx);
            end
        end else begin
            n_free++;
            // lowest active chunk whose span (mod 2^32) holds the address wins
            for (int k = 0; k < live_chunks; k++) begin
                off = addr - chunk_start(k);
                if (pick < 0 && 64'(off) <= 64'(eff) * 64'(SLOTS - 1)) begin
                    pick = k;
                    idx  = int'(off / eff);
                    if (idx > SLOTS - 1) begin
                        idx = SLOTS - 1;
                    end
                end
            end
            if (pick >= 0) begin
                free_map[pick][idx] = 1'b1;
                r.slot_number = 9'(pick * SLOTS + idx);
            end else begin
                r.status = ST_OUTSIDE;
                n_outside++;
            end
        end
        expected_q.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                 n_checked, field, got, want);
        n_errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data);
        t_res got;
        t_res want;
        got = t_res'(data[RES_W-1:0]);
        n_checked++;
        if (expected_q.size() == 0) begin
            report("no request outstanding", 64'(data), 64'd0);
            return;
        end
        want = expected_q.pop_front();
        if (got.slot_address !== want.slot_address) begin
            report("slot_address", 64'(got.slot_address), 64'(want.slot_address));
        end
        if (got.slot_number !== want.slot_number) begin
            report("slot_number", 64'(got.slot_number), 64'(want.slot_number));
        end
        if (got.status !== want.status) begin
            report("status", 64'(got.status), 64'(want.status));
        end
        if (got.chunk_added !== want.chunk_added) begin
            report("chunk_added", 64'(got.chunk_added), 64'(want.chunk_added));
        end
        if (data[OUT_TDATA_W-1:RES_W] !== '0) begin
            report("pad bits", 64'(data[OUT_TDATA_W-1:RES_W]), 64'd0);
        end
    endtask
endclass

module tb_top;

    // cycles without any handshake before the run is declared hung; the
    // slowest request, with its longest gap and stall, stays well inside it
    localparam int STUCK_LIMIT = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] free_address
    logic                   s_axis_tuser;   // [0] command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [31:0] slot_address, [40:32] slot_number, [42:41] status,
    // [43] chunk_added, [47:44] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    slot_pool_scoreboard sb = new();

    bit          req_gaps_on;     // sender inserts random gaps
    bit          rsp_stalls_on;   // receiver inserts random stalls
    int unsigned stuck_cycles;
    int unsigned settings_used;

    bitmap_slot_pool_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall before each result, tready held high
    // across back-to-back results when the drawn stall is zero.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = rsp_stalls_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Result check and hang watchdog, both on the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         STUCK_LIMIT, sb.pending());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks; each is entered and left just after a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_request(t_op op, logic [31:0] addr);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = addr;
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, addr);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // register writes only happen with the pipe drained
    task automatic write_reg(t_cfg_reg r, logic [31:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = r;
        i_cfg_wdata = v;
        @(posedge i_clk);
        sb.configure(r, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_pool(logic [31:0] size, logic [31:0] base);
        drain();
        write_reg(CFG_SLOT_SIZE, size);
        write_reg(CFG_REGION_BASE, base);
        settings_used++;
    endtask

    // Free targets: mostly real slots (with a random byte offset), plus the
    // edges around each chunk and fully random addresses.
    function automatic logic [31:0] pick_free_address();
        int          c;
        int          kind;
        logic [31:0] eff;
        logic [31:0] off;
        eff  = sb.eff_size();
        c    = $urandom_range(0, sb.live_chunks - 1);
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            off = $urandom_range(0, SLOTS - 1) * eff;
            if ($urandom_range(0, 1) == 1) begin
                off = off + $urandom_range(0, eff - 1);
            end
        end else if (kind == 6) begin
            // first byte of the last slot is inside, its tail is not
            off = (SLOTS - 1) * eff + $urandom_range(0, 3);
        end else if (kind == 7) begin
            off = SLOTS * eff + $urandom_range(0, 3);
        end else if (kind == 8) begin
            off = -$urandom_range(1, 4);
        end else begin
            return $urandom;
        end
        return sb.chunk_start(c) + off;
    endfunction

    task automatic run_mix(int count, int free_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 31) == 0) req_gaps_on = !req_gaps_on;
            if ($urandom_range(0, 31) == 0) rsp_stalls_on = !rsp_stalls_on;
            if ($urandom_range(0, 99) < free_pct) begin
                send_request(OP_FREE, pick_free_address());
            end else begin
                send_request(OP_ALLOC, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_SLOT_SIZE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        settings_used = 1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset settings (16-byte slots from address 0)
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h5A5A_A5A5);
        send_request(OP_FREE,  32'd16);            // exact slot address
        send_request(OP_FREE,  32'd16);            // already free again
        send_request(OP_FREE,  32'd35);            // inside slot 2
        send_request(OP_FREE,  32'd1008);          // first byte of last slot
        send_request(OP_FREE,  32'd1009);          // tail of last slot: outside
        send_request(OP_FREE,  32'd1024);          // chunk 1 not active yet
        send_request(OP_FREE,  32'hFFFF_FFFF);
        send_request(OP_FREE,  32'h8000_0000);
        send_request(OP_FREE,  32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);     // lowest slot reused

        // Smallest slots, chunk 0 straddling the top of the address space
        set_pool(32'd4, 32'hFFFF_FFF0);
        run_mix(20, 35);
        drain();                                    // hold off until all results are in
        run_mix(20, 35);

        // Zero size (acts as 4); allocate until the whole pool is used up,
        // then keep asking so the exhausted status shows up.
        set_pool(32'd0, $urandom);
        while (!sb.pool_full()) begin
            if ($urandom_range(0, 63) == 0) req_gaps_on = !req_gaps_on;
            if ($urandom_range(0, 63) == 0) rsp_stalls_on = !rsp_stalls_on;
            send_request(OP_ALLOC, $urandom);
        end
        for (int n = 0; n < 4; n++) begin
            send_request(OP_ALLOC, $urandom);
        end
        run_mix(10, 50);

        // A 64 KiB slot, base at the very top
        set_pool(32'd65536, 32'hFFFF_FFFF);
        run_mix(15, 55);

        // Widest 17-bit size, not a multiple of four
        set_pool(32'h0001_FFFF, 32'h8000_0000);
        run_mix(15, 45);

        // Small odd size at a random base
        set_pool(32'd6, $urandom);
        run_mix(15, 40);

        drain();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d allocates and %0d frees over %0d pool settings, %0d results checked.",
                 sb.n_alloc, sb.n_free, settings_used, sb.n_checked);
        $display("Saw %0d chunk activations, %0d exhausted and %0d outside-pool results.",
                 sb.n_added, sb.n_exhausted, sb.n_outside);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/bspa_pkg.sv
rtl/core/bspa_front.sv
rtl/core/bspa_engine.sv
rtl/core/bitmap_slot_pool_allocator.sv
sim/tb_top.sv
